@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the walk controller of the implicit tree insert block.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checks an implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ibst_pkg.sv @@
// Package for the implicit tree insert block: sizes, status codes and the
// memory request type. No dependencies.
package ibst_pkg;

	localparam int LEVELS = 10;
	localparam int ADDR_W = LEVELS;
	localparam int NODE_COUNT = (1 << LEVELS) - 1;
	localparam int VALUE_W = 32;
	localparam int SLOT_W = 10;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	// One memory entry: occupied flag above the stored value.
	typedef struct packed {
		logic occupied;
		logic signed [VALUE_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic we;
		logic re;
		logic [ADDR_W-1:0] addr;
		entry_t wdata;
	} mem_req_t;

endpackage

@@ hw/rtl/ibst_mem.sv @@
// Node store: one synchronous memory holding an occupied flag and a value per
// slot, with a registered read port. Depends on ibst_pkg.
module ibst_mem (
	input logic clk,
	input ibst_pkg::mem_req_t req,
	output ibst_pkg::entry_t rdata
);

	ibst_pkg::entry_t mem [ibst_pkg::NODE_COUNT];
	ibst_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/ibst_ctrl.sv @@
// Walk controller: clears the node store after reset, then walks it one level
// per cycle for each insert. Depends on ibst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ibst_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [ibst_pkg::VALUE_W-1:0] value,
	output logic busy,
	output logic done,
	output logic [ibst_pkg::STATUS_W-1:0] status,
	output logic [ibst_pkg::SLOT_W-1:0] slot,
	output ibst_pkg::mem_req_t req,
	input ibst_pkg::entry_t rdata
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;

	logic [1:0] state_q, state_d;
	logic [ibst_pkg::ADDR_W-1:0] clr_q;
	logic [ibst_pkg::ADDR_W-1:0] pos_q, pos_d;
	logic signed [ibst_pkg::VALUE_W-1:0] key_q;
	logic done_q, done_d;
	logic [ibst_pkg::STATUS_W-1:0] status_q, status_d;
	logic [ibst_pkg::SLOT_W-1:0] slot_q, slot_d;
	logic [ibst_pkg::ADDR_W:0] next_pos;

	always_comb begin
		next_pos = {pos_q, 1'b0} + ((key_q < rdata.value) ?
			(ibst_pkg::ADDR_W+1)'(1) : (ibst_pkg::ADDR_W+1)'(2));
	end

	always_comb begin
		req = '0;
		state_d = state_q;
		pos_d = pos_q;
		done_d = 1'b0;
		status_d = status_q;
		slot_d = slot_q;
		case (state_q)
			ST_CLEAR: begin
				req.we = 1'b1;
				req.addr = clr_q;
				if (clr_q == ibst_pkg::ADDR_W'(ibst_pkg::NODE_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					req.re = 1'b1;
					req.addr = '0;
					pos_d = '0;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (!rdata.occupied) begin
					req.we = 1'b1;
					req.addr = pos_q;
					req.wdata.occupied = 1'b1;
					req.wdata.value = key_q;
					done_d = 1'b1;
					status_d = ibst_pkg::STATUS_INSERTED;
					slot_d = ibst_pkg::SLOT_W'(pos_q);
					state_d = ST_IDLE;
				end else if (rdata.value == key_q) begin
					done_d = 1'b1;
					status_d = ibst_pkg::STATUS_DUPLICATE;
					slot_d = ibst_pkg::SLOT_W'(pos_q);
					state_d = ST_IDLE;
				end else if (next_pos >= (ibst_pkg::ADDR_W+1)'(ibst_pkg::NODE_COUNT)) begin
					done_d = 1'b1;
					status_d = ibst_pkg::STATUS_FULL;
					slot_d = '0;
					state_d = ST_IDLE;
				end else begin
					req.re = 1'b1;
					req.addr = next_pos[ibst_pkg::ADDR_W-1:0];
					pos_d = next_pos[ibst_pkg::ADDR_W-1:0];
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		status_q <= status_d;
		slot_q <= slot_d;
		if (state_q == ST_IDLE && start) begin
			key_q <= value;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign slot = slot_q;

	`ASSERT_CLK(a_no_rw_clash, !(req.we && req.re), "memory read and write in one cycle")
	`ASSERT_NEXT(a_start_walks, state_q == ST_IDLE && start, state_q == ST_WALK,
		"accepted transaction did not start a walk")
	`ASSERT_CLK(a_full_slot_zero, !done_q || status_q != ibst_pkg::STATUS_FULL || slot_q == '0,
		"full result with a nonzero slot")
	`ASSERT_CLK(a_no_result_in_clear, !(state_q == ST_CLEAR && done_q),
		"result during the clearing pass")

endmodule

@@ hw/rtl/implicit_bst_insert.sv @@
// Implicit binary search tree insert: top level joining the walk controller
// and the node store. Depends on ibst_pkg, ibst_ctrl and ibst_mem.
//
// A transaction is accepted at a rising edge where start is high and busy is
// low; value is taken then. The block walks the tree from slot 0, one level
// per cycle, reading one memory entry each cycle. It writes the value into
// the first empty slot reached, or stops at an equal value, or stops when the
// next slot would lie below the deepest level.
// The result appears on status and slot for exactly one cycle with done high.
// The walk reads one level at a time through the single read port of the node
// store. A new transaction may be accepted in the cycle in which done is
// shown. After reset busy stays high while the store is cleared, one slot
// per cycle. The receiver cannot stall; every result must be taken in the
// cycle it is shown.
module implicit_bst_insert (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [31:0] value,
	output logic busy,
	output logic done,
	output logic [1:0] status,
	output logic [9:0] slot
);

	ibst_pkg::mem_req_t req;
	ibst_pkg::entry_t rdata;

	ibst_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.value(value),
		.busy(busy),
		.done(done),
		.status(status),
		.slot(slot),
		.req(req),
		.rdata(rdata)
	);

	ibst_mem u_mem (
		.clk(clk),
		.req(req),
		.rdata(rdata)
	);

endmodule
